FILE: rtl/bitmap_node_allocator_top_defines.svh
// Assertion macros for the bitmap node allocator.
// Expects clk and arst_n in the scope where a macro is used.
`ifndef BITMAP_NODE_ALLOCATOR_TOP_DEFINES_SVH
`define BITMAP_NODE_ALLOCATOR_TOP_DEFINES_SVH
`ifndef SYNTHESIS
// Same-cycle implication
`define BNA_ASSERT_IMP(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("bitmap node allocator: assertion failed");
// Next-cycle implication
`define BNA_ASSERT_NXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("bitmap node allocator: assertion failed");
`else
`define BNA_ASSERT_IMP(lbl, ante, cons)
`define BNA_ASSERT_NXT(lbl, ante, cons)
`endif
`endif

FILE: rtl/bna_pkg.sv
// Shared constants, types and helper functions for the bitmap node allocator.
// No dependencies.
`default_nettype none
package bna_pkg;

	localparam int NUM_NODES      = 4096;
	localparam int BYTE_W         = 8;
	localparam int MAP_BYTES      = (NUM_NODES + BYTE_W - 1) / BYTE_W;
	localparam int ADDR_W         = (MAP_BYTES > 1) ? $clog2(MAP_BYTES) : 1;
	localparam int NODE_W         = 12;
	localparam int RSV_W          = 4;
	localparam int BIDX_W         = 3;

	localparam logic [RSV_W-1:0]  RESERVED_RESET = RSV_W'(2);
	localparam logic [ADDR_W-1:0] LAST_ADDR      = ADDR_W'(MAP_BYTES - 1);
	localparam logic [BYTE_W-1:0] TOP_BIT        = 8'h80;

	localparam logic [1:0] OP_FORMAT = 2'd0;
	localparam logic [1:0] OP_ALLOC  = 2'd1;
	localparam logic [1:0] OP_QUERY  = 2'd2;

	typedef struct packed {
		logic              we;
		logic [ADDR_W-1:0] waddr;
		logic [BYTE_W-1:0] wdata;
		logic              re;
		logic [ADDR_W-1:0] raddr;
	} mem_req_t;

	// Formatted contents of one map byte: node n is free when it lies at or
	// beyond the reserved count and below the node count. MSB holds the
	// lowest node of the byte.
	function automatic logic [BYTE_W-1:0] fmt_byte(input logic [ADDR_W-1:0] addr,
			input logic [RSV_W-1:0] lim);
		logic [BYTE_W-1:0] v;
		int                n;
		v = '0;
		for (int b = 0; b < BYTE_W; b++) begin
			n = int'(addr) * BYTE_W + b;
			v[BYTE_W-1-b] = (n >= int'(lim)) && (n < NUM_NODES);
		end
		return v;
	endfunction

	// Position of the first set bit counted from the MSB.
	function automatic logic [BIDX_W-1:0] first_bit(input logic [BYTE_W-1:0] v);
		logic [BIDX_W-1:0] p;
		p = '0;
		for (int b = BYTE_W - 1; b >= 0; b--) begin
			if (v[BYTE_W-1-b]) begin
				p = BIDX_W'(b);
			end
		end
		return p;
	endfunction

endpackage
`default_nettype wire

FILE: rtl/bna_map_ram.sv
// Free-node map storage: one byte per word, one write and one read port.
// Depends on bna_pkg.
`default_nettype none
module bna_map_ram
	import bna_pkg::*;
(
	input  wire logic              clk,
	input  wire mem_req_t          req,
	output logic      [BYTE_W-1:0] rdata
);

	logic [BYTE_W-1:0] mem_q [MAP_BYTES];
	logic [BYTE_W-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (req.we) begin
			mem_q[req.waddr] <= req.wdata;
		end
		if (req.re) begin
			rdata_q <= mem_q[req.raddr];
		end
	end

	assign rdata = rdata_q;

endmodule
`default_nettype wire

FILE: rtl/bna_ctrl.sv
// Sequencer for the allocator: format sweep, first-free search, lookup with a
// read of the map memory and, for allocate, a write-back. Depends on bna_pkg.
`default_nettype none
module bna_ctrl
	import bna_pkg::*;
(
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              start,
	output logic                   busy,
	input  wire logic [1:0]        op,
	input  wire logic [NODE_W-1:0] node,
	input  wire logic [RSV_W-1:0]  reserved,
	output mem_req_t               mem_req,
	input  wire logic [BYTE_W-1:0] rdata,
	output logic                   done,
	output logic      [NODE_W-1:0] result_node,
	output logic                   status,
	output logic                   was_free
);

	typedef enum logic [3:0] {
		ST_IDLE   = 4'b0001,
		ST_FORMAT = 4'b0010,
		ST_SEARCH = 4'b0100,
		ST_LOOKUP = 4'b1000
	} state_t;

	state_t              state_q;
	logic [ADDR_W-1:0]   addr_q;
	logic                iss_done_q;
	logic [RSV_W-1:0]    lim_q;
	logic                emit_q;
	logic [1:0]          op_q;
	logic [NODE_W-1:0]   node_q;
	logic                rd_vld_s1;
	logic [ADDR_W-1:0]   rd_addr_s1;
	logic                done_q;
	logic [NODE_W-1:0]   res_q;
	logic                status_q;
	logic                was_q;

	logic                node_ok;
	logic                hit;
	logic                miss_end;
	logic [BIDX_W-1:0]   fbit;
	logic [ADDR_W+BIDX_W-1:0] fnode;
	logic                fzero;
	logic                lk_bit;
	logic [BYTE_W-1:0]   mask_f;
	logic [BYTE_W-1:0]   mask_lk;
	logic [ADDR_W-1:0]   lk_addr;
	logic                search_re;

	assign node_ok  = int'(node) < NUM_NODES;
	assign hit      = (state_q == ST_SEARCH) && rd_vld_s1 && (rdata != '0);
	assign miss_end = (state_q == ST_SEARCH) && rd_vld_s1 && (rdata == '0)
		&& (rd_addr_s1 == LAST_ADDR);
	assign fbit     = first_bit(rdata);
	assign fnode    = {rd_addr_s1, fbit};
	assign fzero    = (fnode == '0);
	assign mask_f   = TOP_BIT >> fbit;
	assign mask_lk  = TOP_BIT >> node_q[BIDX_W-1:0];
	assign lk_bit   = (rdata & mask_lk) != '0;
	assign lk_addr  = ADDR_W'(node_q >> BIDX_W);
	assign search_re = (state_q == ST_SEARCH) && !iss_done_q && !hit;

	always_comb begin
		mem_req = '0;
		case (state_q)
			ST_IDLE: begin
				// launch the lookup read as the item is taken
				if (start && node_ok
						&& (op == OP_QUERY || (op == OP_ALLOC && node != '0))) begin
					mem_req.re    = 1'b1;
					mem_req.raddr = ADDR_W'(node >> BIDX_W);
				end
			end
			ST_FORMAT: begin
				mem_req.we    = 1'b1;
				mem_req.waddr = addr_q;
				mem_req.wdata = fmt_byte(addr_q, lim_q);
			end
			ST_SEARCH: begin
				mem_req.re    = search_re;
				mem_req.raddr = addr_q;
				if (hit && !fzero) begin
					mem_req.we    = 1'b1;
					mem_req.waddr = rd_addr_s1;
					mem_req.wdata = rdata & ~mask_f;
				end
			end
			ST_LOOKUP: begin
				if (op_q == OP_ALLOC) begin
					mem_req.we    = 1'b1;
					mem_req.waddr = lk_addr;
					mem_req.wdata = rdata & ~mask_lk;
				end
			end
			default: begin
				mem_req = '0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_FORMAT;
			addr_q     <= '0;
			iss_done_q <= 1'b0;
			lim_q      <= RESERVED_RESET;
			emit_q     <= 1'b0;
			rd_vld_s1  <= 1'b0;
			done_q     <= 1'b0;
		end else begin
			done_q    <= 1'b0;
			rd_vld_s1 <= search_re;
			case (state_q)
				ST_IDLE: begin
					if (start) begin
						op_q   <= op;
						node_q <= node;
						case (op)
							OP_FORMAT: begin
								lim_q   <= reserved;
								addr_q  <= '0;
								emit_q  <= 1'b1;
								state_q <= ST_FORMAT;
							end
							OP_ALLOC: begin
								if (node == '0) begin
									addr_q     <= '0;
									iss_done_q <= 1'b0;
									state_q    <= ST_SEARCH;
								end else if (node_ok) begin
									state_q <= ST_LOOKUP;
								end else begin
									done_q   <= 1'b1;
									res_q    <= node;
									status_q <= 1'b0;
									was_q    <= 1'b0;
								end
							end
							OP_QUERY: begin
								if (node_ok) begin
									state_q <= ST_LOOKUP;
								end else begin
									done_q   <= 1'b1;
									res_q    <= node;
									status_q <= 1'b0;
									was_q    <= 1'b0;
								end
							end
							default: begin
								done_q   <= 1'b1;
								res_q    <= '0;
								status_q <= 1'b0;
								was_q    <= 1'b0;
							end
						endcase
					end
				end
				ST_FORMAT: begin
					if (addr_q == LAST_ADDR) begin
						state_q  <= ST_IDLE;
						done_q   <= emit_q;
						res_q    <= '0;
						status_q <= 1'b0;
						was_q    <= 1'b0;
					end else begin
						addr_q <= addr_q + ADDR_W'(1);
					end
				end
				ST_SEARCH: begin
					if (search_re) begin
						rd_addr_s1 <= addr_q;
						if (addr_q == LAST_ADDR) begin
							iss_done_q <= 1'b1;
						end else begin
							addr_q <= addr_q + ADDR_W'(1);
						end
					end
					if (hit) begin
						// node 0 found free reads as no space
						state_q  <= ST_IDLE;
						done_q   <= 1'b1;
						res_q    <= fzero ? '0 : NODE_W'(fnode);
						status_q <= fzero;
						was_q    <= !fzero;
					end else if (miss_end) begin
						state_q  <= ST_IDLE;
						done_q   <= 1'b1;
						res_q    <= '0;
						status_q <= 1'b1;
						was_q    <= 1'b0;
					end
				end
				ST_LOOKUP: begin
					state_q  <= ST_IDLE;
					done_q   <= 1'b1;
					res_q    <= node_q;
					status_q <= 1'b0;
					was_q    <= lk_bit;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign busy        = (state_q != ST_IDLE);
	assign done        = done_q;
	assign result_node = res_q;
	assign status      = status_q;
	assign was_free    = was_q;

endmodule
`default_nettype wire

FILE: rtl/bitmap_node_allocator_top.sv
// Top level of the bitmap node allocator: configuration register, sequencer
// and map memory. Depends on bna_pkg, bna_ctrl, bna_map_ram and the defines header.
//
// Channel   Direction  Handshake               Word
// -------   ---------  ----------------------  ------------------------------
// command   in         start & !busy           op, node
// result    out        done (one-cycle strobe) result_node, status, was_free
// config    in         cfg_valid & cfg_ready   cfg_data (reserved node count)
//
// Sequence: query and allocate of a given node read the map byte, then
// allocate writes it back; an unused op code or an out-of-range node answers
// from idle without a map access. Format writes one byte per cycle, and the
// first-free search reads one byte per cycle through the single memory read
// port until it finds a free node or reaches the last byte.
// Reset: a clearing pass formats the map with two reserved nodes while busy
// is high; config writes are taken meanwhile.
// Stalls: the result side cannot stall; each result shows for one cycle.
`default_nettype none
`include "bitmap_node_allocator_top_defines.svh"
module bitmap_node_allocator_top
	import bna_pkg::*;
(
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              start,
	output logic                   busy,
	input  wire logic [1:0]        op,
	input  wire logic [NODE_W-1:0] node,
	input  wire logic              cfg_valid,
	output logic                   cfg_ready,
	input  wire logic [RSV_W-1:0]  cfg_data,
	output logic                   done,
	output logic      [NODE_W-1:0] result_node,
	output logic                   status,
	output logic                   was_free
);

	logic [RSV_W-1:0]  reserved_q;
	mem_req_t          mem_req;
	logic [BYTE_W-1:0] mem_rdata;

	// Accept config words at any time; the user must write only while idle, the block does not enforce it.
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			reserved_q <= RESERVED_RESET;
		end else if (cfg_valid && cfg_ready) begin
			reserved_q <= cfg_data;
		end
	end

	// Sequence every op and own all map accesses.
	bna_ctrl u_ctrl (
		.clk         (clk),
		.arst_n      (arst_n),
		.start       (start),
		.busy        (busy),
		.op          (op),
		.node        (node),
		.reserved    (reserved_q),
		.mem_req     (mem_req),
		.rdata       (mem_rdata),
		.done        (done),
		.result_node (result_node),
		.status      (status),
		.was_free    (was_free)
	);

	// Hold the free map, one bit per node, MSB first in each byte.
	bna_map_ram u_map (
		.clk   (clk),
		.req   (mem_req),
		.rdata (mem_rdata)
	);

	// An accepted command either keeps the block busy or answers next cycle.
	`BNA_ASSERT_NXT(a_cmd_progress, start && !busy, busy || done)
	// Results only appear once the sequencer is back at rest.
	`BNA_ASSERT_IMP(a_done_idle, done, !busy)
	// A no-space answer carries no node and no free flag.
	`BNA_ASSERT_IMP(a_nospace_clean, done && status, result_node == '0 && !was_free)

endmodule
`default_nettype wire
